FILE: src/rtm_pkg.sv
// ----------------------------------------------------------------------------
// rtm_pkg
// Shared types, constants and the reset texture pattern for the
// rotate-and-zoom texture mapper.
// ----------------------------------------------------------------------------
package rtm_pkg;

  // Texture geometry
  localparam int TEX_SIDE  = 16;
  localparam int TEX_LOG   = $clog2(TEX_SIDE);
  localparam int TEX_AW    = 2 * TEX_LOG;
  localparam int TEX_CELLS = TEX_SIDE * TEX_SIDE;

  // Fixed-point layout: coordinate bits taken after the shift by 20
  localparam int FRAC_SHIFT = 20;

  // Queue between front and back
  localparam int Q_DEPTH = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_COS          = 3'd0;
  localparam logic [2:0] REG_SIN          = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COLOR_ZERO   = 3'd4;
  localparam logic [2:0] REG_COLOR_ONE    = 3'd5;
  localparam logic [2:0] REG_COLOR_TWO    = 3'd6;

  // Palette codes
  localparam logic [1:0] PAL_ZERO = 2'd0;
  localparam logic [1:0] PAL_ONE  = 2'd1;
  localparam logic [1:0] PAL_TWO  = 2'd2;

  // Item kinds
  typedef enum logic {
    FUNC_MAP   = 1'b0,
    FUNC_WRITE = 1'b1
  } rtm_func_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    rtm_func_t          func;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic [TEX_AW-1:0]  addr;
    logic [1:0]         value;
  } rtm_item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic signed [11:0] cos_q10;
    logic signed [11:0] sin_q10;
    logic [23:0]        color_zero;
    logic [23:0]        color_one;
    logic [23:0]        color_two;
  } rtm_cfg_t;

  // Reset logo, one row per word, column c in bits [2c+1:2c]
  localparam logic [31:0] LOGO_ROWS [16] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0255_1550, 32'h0200_1000,
    32'h0255_1550, 32'h0001_1000, 32'h0155_1550, 32'h0000_0000,
    32'h0048_4010, 32'h0140_4550, 32'h0044_4420, 32'h0044_4420,
    32'h0144_4560, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  // Reset value of one texel
  function automatic logic [1:0] rtm_logo(input logic [TEX_AW-1:0] addr);
    logic [31:0] row;
    row = LOGO_ROWS[addr[TEX_AW-1:TEX_LOG]];
    return row[{addr[TEX_LOG-1:0], 1'b0} +: 2];
  endfunction

endpackage

FILE: src/rotozoom_texture_mapper_core.sv
// ----------------------------------------------------------------------------
// rotozoom_texture_mapper_core
// Rotate-and-zoom texture mapper with configuration registers.
// ----------------------------------------------------------------------------
// The block takes one item per clock and delivers one result per clock for
// pixel items as long as out_tready stays high; texel-write items give no
// result. From acceptance to out_tvalid a pixel passes the four-entry
// input queue, then the product stage, the zoom stage and the texture
// read (registered RAM port), and its palette entry loads the output
// register. The back pipeline stalls as a whole while a result waits;
// the queue keeps taking items until it holds four. A texel write is
// visible to the item right behind it.
// Texture reset is immediate (per-texel written flags fall back to the logo),
// so no clearing pass follows reset. Registers sit at byte address 4*i:
// cos_q10, sin_q10, frame_width, frame_height, color_zero, color_one,
// color_two; write them only while the block is idle.
// ----------------------------------------------------------------------------
module rotozoom_texture_mapper_core
  import rtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // pixel_x[9:0], pixel_y[19:10],
                                   // texel_address[27:20], texel_value[29:28]
  input  logic        in_tuser,    // func
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // pixel_color[23:0], palette_index[25:24]
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [11:0] cos_r, sin_r;
  logic [10:0]        width_r, height_r;
  logic [23:0]        col0_r, col1_r, col2_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  rtm_cfg_t           cfg;

  rtm_item_t          front_item;
  rtm_item_t          q_head;
  logic               q_not_full, q_not_empty, q_pop, push;

  // Register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r    <= 12'sd1024;
      sin_r    <= 12'sd0;
      width_r  <= 11'd320;
      height_r <= 11'd240;
      col0_r   <= 24'h000000;
      col1_r   <= 24'hFFFFFF;
      col2_r   <= 24'h00FF00;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COS:          cos_r    <= cfg_pwdata[11:0];
        REG_SIN:          sin_r    <= cfg_pwdata[11:0];
        REG_FRAME_WIDTH:  width_r  <= cfg_pwdata[10:0];
        REG_FRAME_HEIGHT: height_r <= cfg_pwdata[10:0];
        REG_COLOR_ZERO:   col0_r   <= cfg_pwdata[23:0];
        REG_COLOR_ONE:    col1_r   <= cfg_pwdata[23:0];
        REG_COLOR_TWO:    col2_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_idx)
      REG_COS:          cfg_prdata = {20'b0, cos_r};
      REG_SIN:          cfg_prdata = {20'b0, sin_r};
      REG_FRAME_WIDTH:  cfg_prdata = {21'b0, width_r};
      REG_FRAME_HEIGHT: cfg_prdata = {21'b0, height_r};
      REG_COLOR_ZERO:   cfg_prdata = {8'b0, col0_r};
      REG_COLOR_ONE:    cfg_prdata = {8'b0, col1_r};
      REG_COLOR_TWO:    cfg_prdata = {8'b0, col2_r};
      default:          cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.cos_q10    = cos_r;
    cfg.sin_q10    = sin_r;
    cfg.color_zero = col0_r;
    cfg.color_one  = col1_r;
    cfg.color_two  = col2_r;
  end

  // Front: classify and centre
  rtm_front u_front (
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .frame_width  (width_r),
    .frame_height (height_r),
    .item         (front_item)
  );

  assign in_tready = q_not_full;
  assign push      = in_tvalid && q_not_full;

  // Queue between front and back
  rtm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: map and look up
  rtm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_vld      (q_not_empty),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/rtm_ram.sv
// ----------------------------------------------------------------------------
// rtm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/rtm_front.sv
// ----------------------------------------------------------------------------
// rtm_front
// Input side: unpack an item, classify it and centre the pixel position on
// half the frame size.
// ----------------------------------------------------------------------------
module rtm_front
  import rtm_pkg::*;
(
  input  logic [31:0] in_tdata,     // pixel_x, pixel_y, texel_address, texel_value
  input  logic        in_tuser,     // func
  input  logic [10:0] frame_width,
  input  logic [10:0] frame_height,
  output rtm_item_t   item
);

  logic [9:0]         pixel_x;
  logic [9:0]         pixel_y;
  logic [9:0]         half_w;
  logic [9:0]         half_h;

  // Unpack fields
  assign pixel_x = in_tdata[9:0];
  assign pixel_y = in_tdata[19:10];
  assign half_w  = frame_width[10:1];
  assign half_h  = frame_height[10:1];

  // Classify and centre
  always_comb begin
    item.func  = rtm_func_t'(in_tuser);
    item.dx    = $signed({1'b0, pixel_x}) - $signed({1'b0, half_w});
    item.dy    = $signed({1'b0, pixel_y}) - $signed({1'b0, half_h});
    item.addr  = in_tdata[27:20];
    item.value = in_tdata[29:28];
  end

endmodule

FILE: src/rtm_queue.sv
// ----------------------------------------------------------------------------
// rtm_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module rtm_queue
  import rtm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rtm_item_t push_item,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output rtm_item_t head
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam logic [PW:0] FULL_CNT = (PW+1)'(Q_DEPTH);

  rtm_item_t     slot_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign not_full  = (count_r != FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != FULL_CNT)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not track a push");

endmodule

FILE: src/rtm_back.sv
// ----------------------------------------------------------------------------
// rtm_back
// Back end: rotate and zoom, texture access and palette lookup in a
// stall-together pipeline that ends in the output register.
// ----------------------------------------------------------------------------
module rtm_back
  import rtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rtm_cfg_t    cfg,
  input  logic        q_vld,
  input  rtm_item_t   q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata     // pixel_color, palette_index
);

  logic adv;

  // Stage 1: four rotation products
  logic               v1_r;
  rtm_func_t          func1_r;
  logic [TEX_AW-1:0]  addr1_r;
  logic [1:0]         val1_r;
  logic signed [22:0] m_xc_r, m_ys_r, m_xs_r, m_yc_r;

  // Stage 2: texture coordinates
  logic               v2_r;
  rtm_func_t          func2_r;
  logic [TEX_AW-1:0]  addr2_r;
  logic [1:0]         val2_r;
  logic [TEX_LOG-1:0] u2_r, tv2_r;
  logic signed [23:0] rot_u, rot_v;
  logic signed [35:0] zoom_u, zoom_v;

  // Stage 3: texture read
  logic               v3_r;
  logic               hit3_r;
  logic [1:0]         logo3_r;
  logic [1:0]         ram_q;
  logic               tex_vld_r [TEX_CELLS];
  logic               wr_en, rd_en;
  logic [TEX_AW-1:0]  rd_addr;

  // Output register
  logic               out_vld_r;
  logic [1:0]         pal;
  logic [23:0]        color;
  logic [23:0]        color_r;
  logic [1:0]         pal_r;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv   = !out_vld_r || out_tready;
  assign q_pop = adv && q_vld;

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= q_item.func;
      addr1_r <= q_item.addr;
      val1_r  <= q_item.value;
      m_xc_r  <= q_item.dx * cfg.cos_q10;
      m_ys_r  <= q_item.dy * cfg.sin_q10;
      m_xs_r  <= q_item.dx * cfg.sin_q10;
      m_yc_r  <= q_item.dy * cfg.cos_q10;
    end
  end

  // Stage 2: combine, zoom, keep the coordinate bits above the fraction
  assign rot_u  = 24'(m_xc_r) - 24'(m_ys_r);
  assign rot_v  = 24'(m_xs_r) + 24'(m_yc_r);
  assign zoom_u = rot_u * cfg.sin_q10;
  assign zoom_v = rot_v * cfg.sin_q10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func2_r <= func1_r;
      addr2_r <= addr1_r;
      val2_r  <= val1_r;
      u2_r    <= zoom_u[FRAC_SHIFT +: TEX_LOG];
      tv2_r   <= zoom_v[FRAC_SHIFT +: TEX_LOG];
    end
  end

  // Stage 3: write a texel or read the flipped row
  assign wr_en   = adv && v2_r && (func2_r == FUNC_WRITE);
  assign rd_en   = adv && v2_r && (func2_r == FUNC_MAP);
  assign rd_addr = {~u2_r, tv2_r};

  rtm_ram #(
    .WIDTH (2),
    .DEPTH (TEX_CELLS)
  ) u_texture (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr2_r),
    .wdata (val2_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Mark written texels; unwritten ones read as the logo
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TEX_CELLS; i++) begin
        tex_vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      tex_vld_r[addr2_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r && (func2_r == FUNC_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit3_r  <= tex_vld_r[rd_addr];
      logo3_r <= rtm_logo(rd_addr);
    end
  end

  // Palette lookup
  always_comb begin
    pal = hit3_r ? ram_q : logo3_r;
    unique case (pal)
      PAL_ZERO: color = cfg.color_zero;
      PAL_ONE:  color = cfg.color_one;
      PAL_TWO:  color = cfg.color_two;
      default:  color = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_r <= color;
      pal_r   <= pal;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, pal_r, color_r};

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !v3_r)
    else $error("texel write produced a result");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> tex_vld_r[$past(addr2_r)])
    else $error("written texel not marked");

  a_map_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v3_r |=> out_vld_r)
    else $error("mapped pixel lost before output");

endmodule
